@@ rtl/core/tlpt_pkg.sv @@
// Shared types and constants for the two-level page table walk core
package tlpt_pkg;

    localparam int POOL_TABLES_DEF = 32;
    localparam int NUM_SPACES_DEF  = 4;
    localparam int ENTRIES         = 1024;
    localparam int INDEX_W         = 10;
    localparam int OFFSET_W        = 12;
    localparam int ADDR_W          = 32;
    localparam int FRAME_W         = ADDR_W - OFFSET_W;
    localparam int DIR_LSB         = 22;
    localparam int TBL_LSB         = 12;

    typedef enum logic {
        REQ_MAP       = 1'b0,
        REQ_TRANSLATE = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_TABLES  = 2'd1,
        ST_NOT_MAPPED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_DIR,
        FSM_TBL
    } fsm_t;

    typedef struct packed {
        logic    clr_step;
        logic    capture;
        logic    map_write;
        logic    alloc;
        logic    tbl_read;
        logic    load_out;
        logic    from_table;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic in_range;
        logic is_map;
        logic dir_present;
        logic pool_full;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/core/tlpt_ctrl.sv @@
// Request sequencer: clearing pass, directory step, table step, result load
module tlpt_ctrl
    import tlpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    fsm_t state_reg;
    fsm_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.out_status = ST_OK;
        in_ready       = 1'b0;
        unique case (state_reg)
            FSM_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = FSM_DIR;
                end
            end
            FSM_DIR:
            begin
                if (sts.out_free)
                begin
                    state_next = FSM_IDLE;
                    if (!sts.in_range)
                    begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = ST_NOT_MAPPED;
                    end
                    else if (sts.is_map)
                    begin
                        cmd.load_out = 1'b1;
                        if (!sts.dir_present && sts.pool_full)
                        begin
                            cmd.out_status = ST_NO_TABLES;
                        end
                        else
                        begin
                            cmd.map_write  = 1'b1;
                            cmd.alloc      = !sts.dir_present;
                            cmd.out_status = ST_OK;
                        end
                    end
                    else if (!sts.dir_present)
                    begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = ST_NOT_MAPPED;
                    end
                    else
                    begin
                        cmd.tbl_read = 1'b1;
                        state_next   = FSM_TBL;
                    end
                end
            end
            FSM_TBL:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.from_table = 1'b1;
                    state_next     = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_CLEAR;
            end
        endcase
    end

endmodule

@@ rtl/core/tlpt_dpath.sv @@
// Directory and table memories, request registers, pool counter, result register
module tlpt_dpath
    import tlpt_pkg::*;
#(
    parameter int POOL_TABLES = POOL_TABLES_DEF,
    parameter int NUM_SPACES  = NUM_SPACES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic                req_type,
    input  logic [1:0]          space_id,
    input  logic [ADDR_W-1:0]   vaddr,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [OFFSET_W-1:0] page_flags,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ADDR_W-1:0]   phys_result,
    output logic [1:0]          status
);

    localparam int IDX_W     = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int SPACE_W   = (NUM_SPACES > 1) ? $clog2(NUM_SPACES) : 1;
    localparam int USED_W    = $clog2(POOL_TABLES + 1);
    localparam int DIR_DEPTH = NUM_SPACES * ENTRIES;
    localparam int TBL_DEPTH = POOL_TABLES * ENTRIES;
    localparam int DADDR_W   = $clog2(DIR_DEPTH);
    localparam int TADDR_W   = $clog2(TBL_DEPTH);
    localparam int DENT_W    = IDX_W + 1;
    localparam int CLR_DEPTH = (DIR_DEPTH > TBL_DEPTH) ? DIR_DEPTH : TBL_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    logic [DENT_W-1:0] dir_mem [DIR_DEPTH];
    logic [ADDR_W-1:0] tbl_mem [TBL_DEPTH];

    logic [DENT_W-1:0]   dir_q_reg;
    logic [ADDR_W-1:0]   tbl_q_reg;
    logic                req_reg;
    logic [1:0]          space_reg;
    logic [ADDR_W-1:0]   va_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic [OFFSET_W-1:0] flags_reg;

    logic [CLR_W-1:0]  clr_cnt_reg;
    logic [CLR_W-1:0]  clr_cnt_next;
    logic [USED_W-1:0] used_reg;
    logic [USED_W-1:0] used_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ADDR_W-1:0] out_phys_reg;
    status_t           out_status_reg;

    logic [DADDR_W-1:0] dir_rd_addr;
    logic [DADDR_W-1:0] dir_req_addr;
    logic [IDX_W-1:0]   tbl_idx;
    logic [TADDR_W-1:0] tbl_req_addr;
    logic               clr_dir_en;
    logic               clr_tbl_en;
    logic               tbl_hit;

    assign dir_rd_addr  = DADDR_W'({SPACE_W'(space_id), vaddr[DIR_LSB +: INDEX_W]});
    assign dir_req_addr = DADDR_W'({SPACE_W'(space_reg), va_reg[DIR_LSB +: INDEX_W]});
    assign tbl_idx      = cmd.alloc ? used_reg[IDX_W-1:0] : dir_q_reg[IDX_W-1:0];
    assign tbl_req_addr = TADDR_W'({tbl_idx, va_reg[TBL_LSB +: INDEX_W]});
    assign clr_dir_en   = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(DIR_DEPTH));
    assign clr_tbl_en   = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(TBL_DEPTH));
    assign tbl_hit      = tbl_q_reg[0];

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step && clr_dir_en)
        begin
            dir_mem[DADDR_W'(clr_cnt_reg)] <= '0;
        end
        else if (cmd.map_write && cmd.alloc)
        begin
            dir_mem[dir_req_addr] <= {1'b1, used_reg[IDX_W-1:0]};
        end
        if (cmd.capture)
        begin
            dir_q_reg <= dir_mem[dir_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step && clr_tbl_en)
        begin
            tbl_mem[TADDR_W'(clr_cnt_reg)] <= '0;
        end
        else if (cmd.map_write)
        begin
            tbl_mem[tbl_req_addr] <= {frame_reg, flags_reg};
        end
        if (cmd.tbl_read)
        begin
            tbl_q_reg <= tbl_mem[tbl_req_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_type;
            space_reg <= space_id;
            va_reg    <= vaddr;
            frame_reg <= paddr[ADDR_W-1:OFFSET_W];
            flags_reg <= page_flags;
        end
        if (cmd.load_out)
        begin
            if (cmd.from_table && tbl_hit)
            begin
                out_phys_reg   <= {tbl_q_reg[ADDR_W-1:OFFSET_W], va_reg[OFFSET_W-1:0]};
                out_status_reg <= ST_OK;
            end
            else if (cmd.from_table)
            begin
                out_phys_reg   <= '0;
                out_status_reg <= ST_NOT_MAPPED;
            end
            else
            begin
                out_phys_reg   <= '0;
                out_status_reg <= cmd.out_status;
            end
        end
    end

    always_comb
    begin
        clr_cnt_next   = cmd.clr_step ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        used_next      = (cmd.map_write && cmd.alloc) ? used_reg + 1'b1 : used_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        sts.clr_last    = (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1));
        sts.in_range    = (int'(space_reg) < NUM_SPACES);
        sts.is_map      = (req_t'(req_reg) == REQ_MAP);
        sts.dir_present = dir_q_reg[DENT_W-1];
        sts.pool_full   = (used_reg >= USED_W'(POOL_TABLES));
        sts.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign phys_result = out_phys_reg;
    assign status      = out_status_reg;

endmodule

@@ rtl/core/two_level_page_table_map_walk_core.sv @@
// Top level of the two-level page table map and walk core
//
//  channel | transfer when       | payload
//  --------+---------------------+------------------------------------------------------
//  request | in_valid & in_ready | req_type, space_id, vaddr, paddr, page_flags
//  result  | out_valid&out_ready | phys_result, status
//
// One request at a time: a map, an out-of-range request and a translate that finds no
// directory entry end in the directory step; a translate that walks both levels also takes
// a table step, a directory memory read followed by a dependent table memory read.
// After reset a clearing pass over max(NUM_SPACES, POOL_TABLES) * 1024 addresses zeroes
// both memories; in_ready stays low until it ends.
// A held result stalls the next request in its directory step until it is taken.
module two_level_page_table_map_walk_core
    import tlpt_pkg::*;
#(
    parameter int POOL_TABLES = POOL_TABLES_DEF,
    parameter int NUM_SPACES  = NUM_SPACES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [1:0]          space_id,
    input  logic [ADDR_W-1:0]   vaddr,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [OFFSET_W-1:0] page_flags,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ADDR_W-1:0]   phys_result,
    output logic [1:0]          status
);

    cmd_t cmd;
    sts_t sts;

    tlpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tlpt_dpath #(
        .POOL_TABLES (POOL_TABLES),
        .NUM_SPACES  (NUM_SPACES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .space_id    (space_id),
        .vaddr       (vaddr),
        .paddr       (paddr),
        .page_flags  (page_flags),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .phys_result (phys_result),
        .status      (status)
    );

endmodule

@@ tb/tb_two_level_page_table_map_walk_core.sv @@
// Self-checking testbench for the two-level page table map and walk core
module tb_two_level_page_table_map_walk_core
    import tlpt_pkg::*;
();

    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_ITEMS   = 98;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAPPED_KEEP   = 512;

    typedef struct packed {
        req_t                kind;
        logic [1:0]          space;
        logic [ADDR_W-1:0]   va;
        logic [ADDR_W-1:0]   pa;
        logic [OFFSET_W-1:0] flags;
    } walk_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] phys;
        status_t           st;
    } walk_result_t;

    typedef struct packed {
        walk_req_t    item;
        logic [5:0]   sweep;
        logic         typed;
        walk_result_t want;
    } stim_row_t;

    localparam int NUM_ROWS = 24;
    localparam stim_row_t STIM_ROWS [0:NUM_ROWS-1] = '{
        '{'{REQ_TRANSLATE, 2'd0, 32'h0000_0000, 32'h0, 12'h000}, 6'd0, 1'b1,
          '{32'h0, ST_NOT_MAPPED}},
        '{'{REQ_MAP, 2'd0, 32'h0000_0000, 32'h0000_0000, 12'h001}, 6'd0, 1'b1,
          '{32'h0, ST_OK}},
        '{'{REQ_TRANSLATE, 2'd0, 32'h0000_0FFF, 32'h0, 12'h000}, 6'd0, 1'b1,
          '{32'h0000_0FFF, ST_OK}},
        '{'{REQ_MAP, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF}, 6'd0, 1'b1,
          '{32'h0, ST_OK}},
        '{'{REQ_TRANSLATE, 2'd3, 32'hFFFF_F000, 32'h0, 12'h000}, 6'd0, 1'b1,
          '{32'hFFFF_F000, ST_OK}},
        '{'{REQ_TRANSLATE, 2'd3, 32'hFFFF_EFFF, 32'h0, 12'h000}, 6'd0, 1'b1,
          '{32'h0, ST_NOT_MAPPED}},
        '{'{REQ_MAP, 2'd1, 32'h0040_0000, 32'h1234_5678, 12'h0FE}, 6'd0, 1'b1,
          '{32'h0, ST_OK}},
        '{'{REQ_TRANSLATE, 2'd1, 32'h0040_0123, 32'h0, 12'h000}, 6'd0, 1'b1,
          '{32'h0, ST_NOT_MAPPED}},
        '{'{REQ_MAP, 2'd2, 32'h8000_0000, 32'hAAAA_A555, 12'h555}, 6'd0, 1'b0,
          '{32'h0, ST_OK}},
        '{'{REQ_TRANSLATE, 2'd2, 32'h8000_0ABC, 32'h0, 12'h000}, 6'd0, 1'b0,
          '{32'h0, ST_OK}},
        '{'{REQ_MAP, 2'd2, 32'h8000_1000, 32'h5555_5AAA, 12'hAAA}, 6'd0, 1'b0,
          '{32'h0, ST_OK}},
        '{'{REQ_TRANSLATE, 2'd2, 32'h8000_1FFF, 32'h0, 12'h000}, 6'd0, 1'b0,
          '{32'h0, ST_OK}},
        '{'{REQ_MAP, 2'd0, 32'h0000_0000, 32'h0000_1000, 12'h003}, 6'd0, 1'b0,
          '{32'h0, ST_OK}},
        '{'{REQ_TRANSLATE, 2'd0, 32'h0000_0010, 32'h0, 12'h000}, 6'd0, 1'b0,
          '{32'h0, ST_OK}},
        '{'{REQ_TRANSLATE, 2'd1, 32'h0000_0000, 32'h0, 12'h000}, 6'd0, 1'b1,
          '{32'h0, ST_NOT_MAPPED}},
        '{'{REQ_TRANSLATE, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF}, 6'd0, 1'b1,
          '{32'h0, ST_NOT_MAPPED}},
        '{'{REQ_MAP, 2'd0, 32'h003F_F000, 32'hFFFF_F000, 12'h001}, 6'd0, 1'b0,
          '{32'h0, ST_OK}},
        '{'{REQ_TRANSLATE, 2'd0, 32'h003F_FFFF, 32'h0, 12'h000}, 6'd0, 1'b0,
          '{32'h0, ST_OK}},
        '{'{REQ_MAP, 2'd1, 32'h0080_0000, 32'h0ABC_D000, 12'h001}, 6'd28, 1'b0,
          '{32'h0, ST_OK}},
        '{'{REQ_MAP, 2'd1, 32'hFFC0_0000, 32'hFFFF_FFFF, 12'hFFF}, 6'd0, 1'b1,
          '{32'h0, ST_NO_TABLES}},
        '{'{REQ_TRANSLATE, 2'd1, 32'hFFC0_0000, 32'h0, 12'h000}, 6'd0, 1'b1,
          '{32'h0, ST_NOT_MAPPED}},
        '{'{REQ_MAP, 2'd1, 32'h0040_1000, 32'h0000_2000, 12'h001}, 6'd0, 1'b0,
          '{32'h0, ST_OK}},
        '{'{REQ_TRANSLATE, 2'd1, 32'h0040_1FFF, 32'h0, 12'h000}, 6'd0, 1'b0,
          '{32'h0, ST_OK}},
        '{'{REQ_TRANSLATE, 2'd1, 32'h0740_0000, 32'h0, 12'h000}, 6'd0, 1'b0,
          '{32'h0, ST_OK}}
    };

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic                req_type   = 1'b0;
    logic [1:0]          space_id   = 2'd0;
    logic [ADDR_W-1:0]   vaddr      = '0;
    logic [ADDR_W-1:0]   paddr      = '0;
    logic [OFFSET_W-1:0] page_flags = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [ADDR_W-1:0]   phys_result;
    logic [1:0]          status;

    bit          dir_valid [NUM_SPACES_DEF][ENTRIES];
    int unsigned dir_slot  [NUM_SPACES_DEF][ENTRIES];
    bit [31:0]   pte_store [int unsigned];
    int unsigned slots_taken;

    walk_result_t pending_walks [$];
    bit [33:0]    mapped_vas [$];
    walk_result_t head_walk;

    bit tx_quiet     = 1'b0;
    bit rx_quiet     = 1'b0;
    bit rx_long_hold = 1'b0;

    int mismatch_count;
    int map_count;
    int translate_count;
    int results_seen;
    int ok_seen;
    int no_tables_seen;
    int not_mapped_seen;

    two_level_page_table_map_walk_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .space_id    (space_id),
        .vaddr       (vaddr),
        .paddr       (paddr),
        .page_flags  (page_flags),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .phys_result (phys_result),
        .status      (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic walk_result_t walk_predict(walk_req_t it);
        walk_result_t res;
        int unsigned  dix;
        int unsigned  tix;
        int unsigned  key;
        bit [31:0]    pte;
        res.phys = '0;
        res.st   = ST_OK;
        dix      = 32'(it.va[ADDR_W-1:DIR_LSB]);
        tix      = 32'(it.va[DIR_LSB-1:TBL_LSB]);
        if (it.space >= NUM_SPACES_DEF)
        begin
            res.st = ST_NOT_MAPPED;
        end
        else if (it.kind == REQ_MAP)
        begin
            if (!dir_valid[it.space][dix])
            begin
                if (slots_taken >= POOL_TABLES_DEF)
                begin
                    res.st = ST_NO_TABLES;
                end
                else
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        pte_store.delete(slots_taken * ENTRIES + i);
                    dir_slot[it.space][dix]  = slots_taken;
                    dir_valid[it.space][dix] = 1'b1;
                    slots_taken++;
                end
            end
            if (res.st == ST_OK)
                pte_store[dir_slot[it.space][dix] * ENTRIES + tix] =
                    {it.pa[ADDR_W-1:TBL_LSB], it.flags};
        end
        else if (!dir_valid[it.space][dix])
        begin
            res.st = ST_NOT_MAPPED;
        end
        else
        begin
            key = dir_slot[it.space][dix] * ENTRIES + tix;
            pte = pte_store.exists(key) ? pte_store[key] : 32'h0;
            if (!pte[0])
                res.st = ST_NOT_MAPPED;
            else
                res.phys = {pte[ADDR_W-1:TBL_LSB], it.va[TBL_LSB-1:0]};
        end
        return res;
    endfunction

    function automatic walk_req_t next_random_req();
        walk_req_t it;
        int        roll;
        bit [33:0] pick;
        it.kind  = req_t'($urandom_range(0, 1));
        it.space = 2'($urandom_range(0, 3));
        it.va    = $urandom();
        it.pa    = $urandom();
        it.flags = OFFSET_W'($urandom_range(0, 4095));
        roll     = $urandom_range(0, 99);
        if (roll < 10 || mapped_vas.size() == 0)
            return it;
        pick     = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
        it.space = pick[33:32];
        if (roll < 55)
        begin
            it.kind = REQ_MAP;
            if (roll < 20)
                it.va[ADDR_W-1:TBL_LSB] = pick[ADDR_W-1:TBL_LSB];
            else
                it.va[ADDR_W-1:DIR_LSB] = pick[ADDR_W-1:DIR_LSB];
            if (roll < 45)
                it.flags[0] = 1'b1;
        end
        else
        begin
            it.kind = REQ_TRANSLATE;
            if (roll < 90)
                it.va[ADDR_W-1:TBL_LSB] = pick[ADDR_W-1:TBL_LSB];
            else
                it.va[ADDR_W-1:DIR_LSB] = pick[ADDR_W-1:DIR_LSB];
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_req(input walk_req_t it, input bit typed,
                            input walk_result_t want);
        walk_result_t model_res;
        int           gap;
        gap = tx_quiet ? 0 : (($urandom_range(0, 1) == 0) ? 0 : gap_len());
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= it.kind;
        space_id   <= it.space;
        vaddr      <= it.va;
        paddr      <= it.pa;
        page_flags <= it.flags;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        model_res = walk_predict(it);
        pending_walks.push_back(typed ? want : model_res);
        if (it.kind == REQ_MAP)
            map_count++;
        else
            translate_count++;
        if (it.kind == REQ_MAP && model_res.st == ST_OK)
        begin
            mapped_vas.push_back({it.space, it.va});
            if (mapped_vas.size() > MAPPED_KEEP)
                void'(mapped_vas.pop_front());
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_walks.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_walks.size() == 0)
            begin
                report_mismatch("result with nothing outstanding", phys_result, 32'h0);
            end
            else
            begin
                head_walk = pending_walks.pop_front();
                if (phys_result !== head_walk.phys)
                    report_mismatch("phys_result", phys_result, head_walk.phys);
                if (status !== head_walk.st)
                    report_mismatch("status", {30'b0, status}, {30'b0, head_walk.st});
                case (head_walk.st)
                    ST_OK:        ok_seen++;
                    ST_NO_TABLES: no_tables_seen++;
                    default:      not_mapped_seen++;
                endcase
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (rx_long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                rx_long_hold = 1'b0;
            end
            else if (rx_quiet)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        walk_req_t    item;
        walk_result_t no_want;
        int           reps;
        no_want = '{32'h0, ST_OK};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            reps = (STIM_ROWS[r].sweep == 0) ? 1 : int'(STIM_ROWS[r].sweep);
            for (int k = 0; k < reps; k++)
            begin
                item    = STIM_ROWS[r].item;
                item.va = item.va + (32'(k) << DIR_LSB);
                send_req(item, STIM_ROWS[r].typed, STIM_ROWS[r].want);
            end
        end
        drain_results();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            tx_quiet = (phase == 1 || phase == 3);
            rx_quiet = (phase == 1);
            if (phase == 3)
                rx_long_hold = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_req(next_random_req(), 1'b0, no_want);
            if (phase % 3 == 2)
                drain_results();
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d map and %0d translate requests, %0d results checked",
                 map_count, translate_count, results_seen);
        $display("outcomes: %0d ok, %0d out of tables, %0d not mapped, %0d mismatches",
                 ok_seen, no_tables_seen, not_mapped_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/tlpt_pkg.sv
rtl/core/tlpt_ctrl.sv
rtl/core/tlpt_dpath.sv
rtl/core/two_level_page_table_map_walk_core.sv
tb/tb_two_level_page_table_map_walk_core.sv
